FILE: sv/lpsd_pkg.sv
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and codes of the length-prefixed string decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpsd_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES = 1'd1;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_SHORT_LEN = 3'd1;
  localparam status_t ST_LEN_OVF   = 3'd2;
  localparam status_t ST_TXT_OVR   = 3'd3;
  localparam status_t ST_TXT_UNT   = 3'd4;
  localparam status_t ST_U16_OVR   = 3'd5;
  localparam status_t ST_U16_UNT   = 3'd6;

  // Results caused by one input item: up to three bytes, or one end-of-string marker
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            done;
    status_t         status;
  } bundle_t;

endpackage

FILE: sv/lpsd_if.sv
// ----------------------------------------------------------------------------
// lpsd_in_if / lpsd_out_if
// Valid/ready channels for input bytes and decoded result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpsd_out_if;
  logic             valid;
  logic             ready;
  logic [7:0]       text_byte;
  logic             text_valid;
  logic             run_last;
  logic             string_done;
  lpsd_pkg::status_t status;

  modport source (output valid, output text_byte, output text_valid, output run_last,
                  output string_done, output status, input ready);
  modport sink   (input valid, input text_byte, input text_valid, input run_last,
                  input string_done, input status, output ready);
endinterface

FILE: sv/lpsd_parser.sv
// ----------------------------------------------------------------------------
// lpsd_parser
// Parse state, configuration registers and per-byte decode into a result bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpsd_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [7:0]                          data_byte,
  input  logic                                cfg_we,
  input  logic [lpsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output lpsd_pkg::bundle_t                   bundle
);

  localparam logic [2:0] PH_LEN0 = 3'd0;
  localparam logic [2:0] PH_LEN1 = 3'd1;
  localparam logic [2:0] PH_LEN2 = 3'd2;
  localparam logic [2:0] PH_LEN3 = 3'd3;
  localparam logic [2:0] PH_TEXT = 3'd4;
  localparam logic [2:0] PH_U16A = 3'd5;
  localparam logic [2:0] PH_U16B = 3'd6;

  localparam logic [31:0] LEN_MIN_NEG = 32'h8000_0000;

  logic        big_endian_r, big_endian_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] length_r, length_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] units_left_r, units_left_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [31:0] bytes_dec;
  logic [31:0] units_dec;
  logic [31:0] len_new;
  logic [31:0] neg_units;
  logic [15:0] cp;
  logic        restart;

  always_comb begin
    bytes_dec = bytes_left_r - ((bytes_left_r != '0) ? 32'd1 : 32'd0);
    units_dec = units_left_r - ((units_left_r != '0) ? 32'd1 : 32'd0);
    if (big_endian_r) begin
      len_new = {length_r[23:0], data_byte};
    end else begin
      len_new = length_r | ({24'd0, data_byte} << {phase_r[1:0], 3'b000});
    end
    neg_units = 32'd0 - len_new;
    cp = big_endian_r ? {held_r, data_byte} : {data_byte, held_r};
  end

  always_comb begin
    big_endian_nxt = big_endian_r;
    phase_nxt      = phase_r;
    length_nxt     = length_r;
    bytes_left_nxt = bytes_left_r;
    units_left_nxt = units_left_r;
    held_nxt       = held_r;
    restart        = 1'b0;
    bundle         = '0;
    bundle.status  = lpsd_pkg::ST_OK;

    if (cfg_we) begin
      if (cfg_index == lpsd_pkg::REG_BIG_ENDIAN) begin
        big_endian_nxt = cfg_wdata[0];
      end else if (cfg_index == lpsd_pkg::REG_BUFFER_BYTES) begin
        bytes_left_nxt = cfg_wdata;
        restart        = 1'b1;
      end
    end else if (accept) begin
      bytes_left_nxt = bytes_dec;
      unique case (phase_r) inside
        PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
          if (phase_r == PH_LEN0 && bytes_left_r < 32'd4) begin
            bundle.count  = 2'd1;
            bundle.done   = 1'b1;
            bundle.status = lpsd_pkg::ST_SHORT_LEN;
            restart       = 1'b1;
          end else begin
            length_nxt = len_new;
            if (phase_r != PH_LEN3) begin
              phase_nxt = phase_r + 3'd1;
            end else if (len_new == '0) begin
              bundle.count = 2'd1;
              bundle.done  = 1'b1;
              restart      = 1'b1;
            end else if (len_new == LEN_MIN_NEG) begin
              bundle.count  = 2'd1;
              bundle.done   = 1'b1;
              bundle.status = lpsd_pkg::ST_LEN_OVF;
              restart       = 1'b1;
            end else if (!len_new[31]) begin
              if (len_new > bytes_dec) begin
                bundle.count  = 2'd1;
                bundle.done   = 1'b1;
                bundle.status = lpsd_pkg::ST_TXT_OVR;
                restart       = 1'b1;
              end else begin
                units_left_nxt = len_new;
                phase_nxt      = PH_TEXT;
              end
            end else begin
              if (neg_units > {1'b0, bytes_dec[31:1]}) begin
                bundle.count  = 2'd1;
                bundle.done   = 1'b1;
                bundle.status = lpsd_pkg::ST_U16_OVR;
                restart       = 1'b1;
              end else begin
                units_left_nxt = neg_units;
                phase_nxt      = PH_U16A;
              end
            end
          end
        end
        PH_TEXT: begin
          units_left_nxt = units_dec;
          bundle.count   = 2'd1;
          if (units_dec == '0) begin
            bundle.done   = 1'b1;
            bundle.status = (data_byte == 8'd0) ? lpsd_pkg::ST_OK : lpsd_pkg::ST_TXT_UNT;
            restart       = 1'b1;
          end else begin
            bundle.bytes[0] = data_byte;
          end
        end
        PH_U16A: begin
          held_nxt  = data_byte;
          phase_nxt = PH_U16B;
        end
        PH_U16B: begin
          if (units_left_r <= 32'd1) begin
            bundle.count  = 2'd1;
            bundle.done   = 1'b1;
            bundle.status = (cp == 16'd0) ? lpsd_pkg::ST_OK : lpsd_pkg::ST_U16_UNT;
            restart       = 1'b1;
          end else begin
            // UTF-8 encode, one to three bytes
            if (cp < 16'h0080) begin
              bundle.count    = 2'd1;
              bundle.bytes[0] = cp[7:0];
            end else if (cp < 16'h0800) begin
              bundle.count    = 2'd2;
              bundle.bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
              bundle.bytes[1] = 8'h80 | {2'd0, cp[5:0]};
            end else begin
              bundle.count    = 2'd3;
              bundle.bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
              bundle.bytes[1] = 8'h80 | {2'd0, cp[11:6]};
              bundle.bytes[2] = 8'h80 | {2'd0, cp[5:0]};
            end
            units_left_nxt = units_left_r - 32'd1;
            held_nxt       = 8'd0;
            phase_nxt      = PH_U16A;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end

    if (restart) begin
      phase_nxt      = PH_LEN0;
      length_nxt     = '0;
      units_left_nxt = '0;
      held_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
      phase_r      <= PH_LEN0;
      length_r     <= '0;
      bytes_left_r <= '0;
      units_left_r <= '0;
      held_r       <= '0;
    end else begin
      big_endian_r <= big_endian_nxt;
      phase_r      <= phase_nxt;
      length_r     <= length_nxt;
      bytes_left_r <= bytes_left_nxt;
      units_left_r <= units_left_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

FILE: sv/length_prefixed_string_decoder_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_string_decoder_core
// The first result of an item is offered in the cycle after the item is accepted.
// Throughput: one item per cycle while each gives at most one result and the
// receiver is ready; an item with more results (two or three UTF-8 bytes) holds
// the input as the single result register drains them, one per ready cycle.
// Reset (rst_n low, synchronous): empty result register, little-endian order,
// buffer size zero, parser waiting for the first length byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_string_decoder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  lpsd_in_if.sink                         in_ch,
  lpsd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Result register: the whole bundle of one item, drained one byte per cycle while the receiver is ready
  lpsd_pkg::bundle_t bundle_new;
  lpsd_pkg::bundle_t bundle_r, bundle_nxt;
  logic [1:0]        idx_r, idx_nxt;

  logic in_acc;
  logic out_pop;
  logic at_last;

  assign at_last = (idx_r == (bundle_r.count - 2'd1));
  assign out_pop = out_ch.valid && out_ch.ready;

  // Take a new item when the register is empty or its last result leaves now
  assign in_ch.ready = (bundle_r.count == 2'd0) || (out_pop && at_last);
  assign in_acc      = in_ch.valid && in_ch.ready;

  lpsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .data_byte (in_ch.data_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .bundle    (bundle_new)
  );

  always_comb begin
    bundle_nxt = bundle_r;
    idx_nxt    = idx_r;
    if (in_acc) begin
      // load the new bundle; an item with no result leaves it empty
      bundle_nxt = bundle_new;
      idx_nxt    = 2'd0;
    end else if (out_pop && at_last) begin
      // drop the drained bundle
      bundle_nxt.count = 2'd0;
      idx_nxt          = 2'd0;
    end else if (out_pop) begin
      // advance to the next UTF-8 byte
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bundle_r <= '0;
      idx_r    <= 2'd0;
    end else begin
      bundle_r <= bundle_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // End-of-string markers carry no character byte
  assign out_ch.valid       = (bundle_r.count != 2'd0);
  assign out_ch.text_byte   = bundle_r.done ? 8'd0 : bundle_r.bytes[idx_r];
  assign out_ch.text_valid  = !bundle_r.done;
  assign out_ch.run_last    = at_last;
  assign out_ch.string_done = bundle_r.done;
  assign out_ch.status      = bundle_r.status;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (idx_r < bundle_r.count))
    else $error("result index beyond bundle count");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && bundle_r.done) |-> (bundle_r.count == 2'd1))
    else $error("end-of-string bundle holds more than one result");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && at_last && !in_acc) |=> !out_ch.valid)
    else $error("result register not empty after last result left");

  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !bundle_r.done) |-> (bundle_r.status == lpsd_pkg::ST_OK))
    else $error("error status on a character byte");
`endif

endmodule

FILE: dv/tb_length_prefixed_string_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_string_decoder_core
// Self-checking bench for the length-prefixed string decoder. A generator
// builds byte streams of length-prefixed 8-bit and UTF-16 strings, mostly
// well formed, with empty strings, overflow and overrun lengths, missing
// terminators, bytes past the buffer end and some raw noise. A clocked driver
// streams them in bursts, a parser mirror predicts every decoded item, and a
// clocked monitor checks each accepted item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_length_prefixed_string_decoder_core;

  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no item moved
  localparam int unsigned RAND_ITEMS   = 330;
  localparam int unsigned PAUSE_AT     = 150;   // sender waits for a full drain here
  localparam int unsigned HOLDOFF_AT   = 60;    // receiver starts its long hold-off here
  localparam int unsigned HOLDOFF_LEN  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Parser phases of the mirror
  typedef enum logic [2:0] {
    PRS_LEN0, PRS_LEN1, PRS_LEN2, PRS_LEN3, PRS_TEXT, PRS_UNIT_A, PRS_UNIT_B
  } prs_phase_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

  // One decoded item as seen on the result channel
  typedef struct {
    logic [7:0]        text_byte;
    logic              text_valid;
    logic              run_last;
    logic              string_done;
    lpsd_pkg::status_t status;
  } decoded_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                            cfg_we    = 1'b0;
  logic [lpsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lpsd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte  = 8'd0;
  logic       rx_ready  = 1'b0;

  lpsd_in_if  in_ch();
  lpsd_out_if out_ch();

  assign in_ch.valid     = drv_valid;
  assign in_ch.data_byte = drv_byte;
  assign out_ch.ready    = rx_ready;

  length_prefixed_string_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Parser mirror: byte order, buffer count and string state
  // --------------------------------------------------------------------------
  logic        ord_big   = 1'b0;
  prs_phase_t  prs_phase = PRS_LEN0;
  logic [31:0] prs_len   = '0;
  logic [31:0] prs_left  = '0;
  logic [31:0] prs_units = '0;
  logic [7:0]  prs_held  = '0;

  decoded_t    decoded_q[$];   // decoded items still owed by the block
  logic [7:0]  byte_q[$];      // bytes waiting to be streamed in

  int unsigned sent_count   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;

  // Generator view of the stream being built
  logic        gen_big   = 1'b0;
  logic [31:0] gen_left  = '0;
  int unsigned gen_count = 0;

  function automatic void parser_restart();
    prs_phase = PRS_LEN0;
    prs_len   = '0;
    prs_units = '0;
    prs_held  = '0;
  endfunction

  function automatic decoded_t mk_item(logic [7:0] tb, logic tv, logic done,
                                       lpsd_pkg::status_t st);
    decoded_t d;
    d.text_byte   = tb;
    d.text_valid  = tv;
    d.run_last    = 1'b0;
    d.string_done = done;
    d.status      = st;
    return d;
  endfunction

  // Advance the mirror by one input byte and queue the items it causes
  function automatic void decode_byte(logic [7:0] b);
    decoded_t    res[3];
    int          n;
    logic [31:0] avail;
    logic [31:0] units;
    logic [15:0] cp;
    n     = 0;
    avail = prs_left;
    // Count down the buffer, holding at zero past its end
    if (prs_left != 0) prs_left--;

    if (prs_phase <= PRS_LEN3) begin
      if (prs_phase == PRS_LEN0 && avail < 4) begin
        // Not even a length field fits: report at once, retry on the next byte
        res[n] = mk_item(8'd0, 1'b0, 1'b1, lpsd_pkg::ST_SHORT_LEN); n++;
        parser_restart();
      end else begin
        if (ord_big) prs_len = {prs_len[23:0], b};
        else         prs_len = prs_len | ({24'd0, b} << (8 * int'(prs_phase)));
        if (prs_phase < PRS_LEN3) begin
          prs_phase = prs_phase_t'(prs_phase + 1);
        end else if (prs_len == 32'd0) begin
          res[n] = mk_item(8'd0, 1'b0, 1'b1, lpsd_pkg::ST_OK); n++;
          parser_restart();
        end else if (prs_len == 32'h8000_0000) begin
          res[n] = mk_item(8'd0, 1'b0, 1'b1, lpsd_pkg::ST_LEN_OVF); n++;
          parser_restart();
        end else if (!prs_len[31]) begin
          if (prs_len > prs_left) begin
            res[n] = mk_item(8'd0, 1'b0, 1'b1, lpsd_pkg::ST_TXT_OVR); n++;
            parser_restart();
          end else begin
            prs_units = prs_len;
            prs_phase = PRS_TEXT;
          end
        end else begin
          units = 32'd0 - prs_len;
          if (units > prs_left / 2) begin
            res[n] = mk_item(8'd0, 1'b0, 1'b1, lpsd_pkg::ST_U16_OVR); n++;
            parser_restart();
          end else begin
            prs_units = units;
            prs_phase = PRS_UNIT_A;
          end
        end
      end
    end else if (prs_phase == PRS_TEXT) begin
      if (prs_units != 0) prs_units--;
      if (prs_units == 0) begin
        // Final byte is the terminator
        res[n] = mk_item(8'd0, 1'b0, 1'b1,
                         (b == 8'd0) ? lpsd_pkg::ST_OK : lpsd_pkg::ST_TXT_UNT); n++;
        parser_restart();
      end else begin
        res[n] = mk_item(b, 1'b1, 1'b0, lpsd_pkg::ST_OK); n++;
      end
    end else if (prs_phase == PRS_UNIT_A) begin
      prs_held  = b;
      prs_phase = PRS_UNIT_B;
    end else begin
      cp = ord_big ? {prs_held, b} : {b, prs_held};
      if (prs_units <= 1) begin
        res[n] = mk_item(8'd0, 1'b0, 1'b1,
                         (cp == 16'd0) ? lpsd_pkg::ST_OK : lpsd_pkg::ST_U16_UNT); n++;
        parser_restart();
      end else begin
        // Re-encode one unit as UTF-8; surrogates go through as plain units
        if (cp < 16'h0080) begin
          res[n] = mk_item(cp[7:0], 1'b1, 1'b0, lpsd_pkg::ST_OK); n++;
        end else if (cp < 16'h0800) begin
          res[n] = mk_item(8'hC0 | {3'd0, cp[10:6]}, 1'b1, 1'b0, lpsd_pkg::ST_OK); n++;
          res[n] = mk_item(8'h80 | {2'd0, cp[5:0]}, 1'b1, 1'b0, lpsd_pkg::ST_OK); n++;
        end else begin
          res[n] = mk_item(8'hE0 | {4'd0, cp[15:12]}, 1'b1, 1'b0, lpsd_pkg::ST_OK); n++;
          res[n] = mk_item(8'h80 | {2'd0, cp[11:6]}, 1'b1, 1'b0, lpsd_pkg::ST_OK); n++;
          res[n] = mk_item(8'h80 | {2'd0, cp[5:0]}, 1'b1, 1'b0, lpsd_pkg::ST_OK); n++;
        end
        prs_units--;
        prs_held  = '0;
        prs_phase = PRS_UNIT_A;
      end
    end

    if (n > 0) res[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q = {decoded_q, res[i]};
  endfunction

  // --------------------------------------------------------------------------
  // Stream builders
  // --------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    byte_q = {byte_q, b};
    gen_count++;
    if (gen_left != 0) gen_left--;
  endfunction

  function automatic void push_word(logic [31:0] w);
    for (int i = 0; i < 4; i++)
      push_byte(gen_big ? w[31-8*i -: 8] : w[8*i +: 8]);
  endfunction

  function automatic void push_unit(logic [15:0] u);
    if (gen_big) begin
      push_byte(u[15:8]); push_byte(u[7:0]);
    end else begin
      push_byte(u[7:0]);  push_byte(u[15:8]);
    end
  endfunction

  function automatic logic [15:0] rand_unit();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: return 16'($urandom_range(16'hD800, 16'hDFFF));  // lone surrogates
    endcase
  endfunction

  // Append one string, sized against what is left in the buffer
  function automatic void gen_string();
    logic [31:0] avail;
    logic [31:0] units;
    int unsigned kind;
    int unsigned cnt;
    avail = gen_left - 4;
    kind  = $urandom_range(0, 99);
    if (kind < 35 && avail >= 1) begin
      // 8-bit text, mostly terminated
      cnt = $urandom_range(1, (avail < 6) ? avail : 6);
      push_word(cnt);
      repeat (cnt - 1) push_byte(8'($urandom));
      push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
    end else if (kind >= 35 && kind < 70 && avail >= 2) begin
      // UTF-16 units, mostly terminated
      cnt = $urandom_range(1, (avail / 2 < 4) ? avail / 2 : 4);
      push_word(32'd0 - cnt);
      repeat (cnt - 1) push_unit(rand_unit());
      push_unit(($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'd0);
    end else if (kind >= 78 && kind < 83) begin
      push_word(32'h8000_0000);
    end else if (kind >= 83 && kind < 91) begin
      // Body one or a few bytes beyond the buffer end
      if (avail < 32'h7FFF_FFF0 && $urandom_range(0, 1) == 1) begin
        push_word(avail + 1 + $urandom_range(0, 3));
      end else begin
        units = avail / 2 + 1 + $urandom_range(0, 3);
        if (units > 32'h7FFF_FFFF) units = 32'h7FFF_FFFF;
        push_word(32'd0 - units);
      end
    end else if (kind >= 91) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end else begin
      push_word(32'd0);  // empty string, also the fallback when no body fits
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, configuration and phase control
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hold until every byte is in and every decoded item is out, then let a
  // trailing length byte settle
  task automatic wait_drained();
    while (byte_q.size() != 0 || decoded_q.size() != 0 || drv_valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [lpsd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      lpsd_pkg::REG_BIG_ENDIAN: ord_big = data[0];
      lpsd_pkg::REG_BUFFER_BYTES: begin
        prs_left = data;
        parser_restart();
      end
      default: ;
    endcase
  endtask

  task automatic set_config(logic big, logic [31:0] buf_bytes);
    wait_drained();
    write_reg(lpsd_pkg::REG_BIG_ENDIAN, {31'd0, big});
    write_reg(lpsd_pkg::REG_BUFFER_BYTES, buf_bytes);
    @(posedge clk);
    cfg_we   <= 1'b0;
    gen_big  = big;
    gen_left = buf_bytes;
  endtask

  initial begin : main_seq
    logic        big;
    logic [31:0] buf_bytes;
    int unsigned start;
    int unsigned target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty buffer: every byte is past the end and reports a short length
    set_config(1'b0, 32'd0);
    push_byte(8'h00);
    push_byte(8'hFF);

    // Big-endian UTF-16 with one-, two- and three-byte encodings, then an
    // empty string, the overflow length, and one byte past the end
    set_config(1'b1, 32'd20);
    push_word(32'hFFFF_FFFC);
    push_unit(16'h007F);
    push_unit(16'h07FF);
    push_unit(16'hFFFF);
    push_unit(16'h0000);
    push_word(32'd0);
    push_word(32'h8000_0000);
    push_byte(8'hA5);

    // Largest buffer, little-endian text missing its terminator
    set_config(1'b0, 32'hFFFF_FFFF);
    push_word(32'd2);
    push_byte(8'hFF);
    push_byte(8'h01);

    // Random phases: mostly small buffers so the end of the buffer is hit often
    start = gen_count;
    while (gen_count - start < RAND_ITEMS) begin
      big = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       buf_bytes = 32'hFFFF_FFFF;
        1:       buf_bytes = $urandom;
        2:       buf_bytes = $urandom_range(0, 3);
        default: buf_bytes = $urandom_range(8, 48);
      endcase
      set_config(big, buf_bytes);
      target = gen_count + $urandom_range(16, 48);
      while (gen_count < target && gen_left >= 4) gen_string();
      // Run off the end of the buffer now and then
      if (gen_left < 4) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_length_prefixed_string_decoder_core passed");
    end else begin
      $display("tb_length_prefixed_string_decoder_core failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;
  logic        pause_done = 1'b0;

  always @(posedge clk) begin : drive_proc
    logic took;
    logic offer;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      took = drv_valid && in_ch.ready;
      if (took) begin
        void'(byte_q.pop_front());
        decode_byte(drv_byte);
        sent_count++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = $urandom_range(0, 6);
          burst_left = $urandom_range(1, 16);
          // Now and then run a long stretch with no gaps at all
          if ($urandom_range(0, 7) == 0) begin
            gap_left   = 0;
            burst_left = 60;
          end
        end
      end
      // Hold an offered byte until it is taken
      if (!drv_valid || took) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pause_done && sent_count >= PAUSE_AT && decoded_q.size() != 0) begin
          offer = 1'b0;  // wait for the block to hand over everything it owes
        end else begin
          if (sent_count >= PAUSE_AT) pause_done = 1'b1;
          offer = (byte_q.size() != 0);
        end
        drv_valid <= offer;
        if (offer) drv_byte <= byte_q[0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switch among stall patterns, with one long hold-off
  // --------------------------------------------------------------------------
  rx_mode_t    rx_mode     = RX_FREE;
  int unsigned mode_cnt    = 0;
  logic [15:0] rx_pat      = '0;
  int unsigned hold_cnt    = 0;
  logic        holdoff_done = 1'b0;

  always @(posedge clk) begin : ready_proc
    logic rdy;
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 1'b0;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
        // Hold off long enough for the block to back up into its input
        holdoff_done = 1'b1;
        hold_cnt     = HOLDOFF_LEN;
        rdy          = 1'b0;
      end else begin
        if (mode_cnt == 0) begin
          rx_mode  = rx_mode_t'($urandom_range(0, 3));
          mode_cnt = $urandom_range(20, 80);
          rx_pat   = 16'($urandom);
        end
        mode_cnt--;
        case (rx_mode)
          RX_FREE:   rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          RX_MOSTLY: rdy = ($urandom_range(0, 4) != 0);
          default: begin
            rdy    = rx_pat[0];
            rx_pat = {rx_pat[0], rx_pat[15:1]};
          end
        endcase
      end
      rx_ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted item with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    decoded_t want;
    if (rst_n && out_ch.valid && rx_ready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $error("unexpected item: text_byte %02h done %0b status %0d",
               out_ch.text_byte, out_ch.string_done, out_ch.status);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.text_byte !== want.text_byte) begin
          $error("text_byte: expected %02h, got %02h", want.text_byte, out_ch.text_byte);
          fail_count++;
        end
        if (out_ch.text_valid !== want.text_valid) begin
          $error("text_valid: expected %0b, got %0b", want.text_valid, out_ch.text_valid);
          fail_count++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
          fail_count++;
        end
        if (out_ch.string_done !== want.string_done) begin
          $error("string_done: expected %0b, got %0b", want.string_done, out_ch.string_done);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no item moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((drv_valid && in_ch.ready) || (out_ch.valid && rx_ready)) idle_cycles <= 0;
    else                                                          idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_length_prefixed_string_decoder_core failed");
    $finish;
  end

endmodule
